// File: sv/hte_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hte_pkg: shared types and constants for the table-driven Huffman encoder
// Holds the item kinds, fixed field widths and the control/status bundles
// that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package hte_pkg;

	// fixed field widths
	localparam int SYM_W   = 8;
	localparam int WORD_W  = 16;
	localparam int LEN_W   = 5;
	localparam int KIND_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int VBITS_W = 4;
	localparam int CNT_W   = 3;    // pending bit count, 0..7
	localparam int PEND_W  = 7;    // pending bits, right aligned
	localparam int TOTAL_W = 5;    // pending plus code length, up to 23
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;

	// item kinds; code 3 is unused and falls to a default arm
	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FLUSH  = 2'd2
	} kind_t;

	// commands from controller to datapath
	typedef struct packed {
		logic cap;        // capture input beat
		logic wr;         // write table entry
		logic rd;         // read table entry
		logic acc_load;   // merge looked-up code into accumulator
		logic emit;       // move one full byte to output register
		logic pend_upd;   // keep leftover bits as pending
		logic flush;      // move partial byte with last mark to output
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  in_range;
		logic  len_zero;
		logic  total_ge8;
		logic  out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: sv/huffman_table_encoder_core.sv
`default_nettype none
// Order: an encode beat goes through table read, merge into the accumulator and then byte
// emission to m_tvalid; a flush beat moves the partial byte out, and a load writes the table.
// Flow: one item at a time; s_tready returns once the item is finished, and output
// back-pressure (m_tready low) can hold an encode or flush item and so delay it.
// Reset: arst_n clears the accumulator, the output valid and all table valid flags,
// so every symbol reads as absent until it is loaded.
// ---------------------------------------------------------------------------
// huffman_table_encoder_core: table-driven Huffman bit packer
// Loads per-symbol codes, packs encoded symbols MSB first into bytes and
// flushes the final partial byte with a last mark.
// ---------------------------------------------------------------------------
module huffman_table_encoder_core #(
	parameter int MAX_CODE_LEN = 16,
	parameter int SYMBOL_COUNT = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input beats
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// symbol[7:0], code_word[23:8], code_length[28:24], zero[31:29]
	input  wire logic [hte_pkg::IN_TDATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  wire logic [hte_pkg::KIND_W-1:0]      s_tuser,
	// result beats
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// out_byte[7:0], valid_bits[11:8], zero[15:12]
	output logic      [hte_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                                 m_tlast
);

	hte_pkg::ctrl_cmd_t cmd;
	hte_pkg::dp_stat_t  stat;

	hte_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	hte_datapath #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

`default_nettype wire

// File: sv/hte_code_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hte_code_store: per-symbol code table
// Single-port memory of code word and length, with one valid flip-flop per
// entry so that entries never written read back as length zero.
// ---------------------------------------------------------------------------
module hte_code_store #(
	parameter int SYMBOL_COUNT = 256,
	parameter int CWORD_W      = 16,
	parameter int CLEN_W       = 5
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr,
	input  wire logic                            rd,
	input  wire logic [$clog2(SYMBOL_COUNT)-1:0] addr,
	input  wire logic [CWORD_W-1:0]              wr_word,
	input  wire logic [CLEN_W-1:0]               wr_len,
	output logic      [CWORD_W-1:0]              rd_word,
	output logic      [CLEN_W-1:0]               rd_len
);

	localparam int ENTRY_W = CWORD_W + CLEN_W;

	logic [ENTRY_W-1:0]      mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] valid_q;
	logic [ENTRY_W-1:0]      rd_entry_q;
	logic                    rd_valid_q;

	// memory array, no reset
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[addr] <= {wr_len, wr_word};
		end
		if (rd) begin
			rd_entry_q <= mem[addr];
		end
	end

	// valid flags, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr) begin
				valid_q[addr] <= 1'b1;
			end
			if (rd) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	// unwritten entries read as absent
	assign rd_word = rd_entry_q[CWORD_W-1:0];
	assign rd_len  = rd_valid_q ? rd_entry_q[ENTRY_W-1:CWORD_W] : '0;

endmodule

`default_nettype wire

// File: sv/hte_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hte_datapath: input capture, code table, bit accumulator and output register
// Acts on commands from the controller (the output valid also clears on m_tready) and reports status back.
// ---------------------------------------------------------------------------
module hte_datapath #(
	parameter int MAX_CODE_LEN = 16,
	parameter int SYMBOL_COUNT = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire hte_pkg::ctrl_cmd_t                 cmd,
	output hte_pkg::dp_stat_t                       stat,
	input  wire logic [hte_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  wire logic [hte_pkg::KIND_W-1:0]         s_tuser,
	input  wire logic                               m_tready,
	output logic                                    m_tvalid,
	output logic      [hte_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                    m_tlast
);

	// stored code width: smaller of the parameter and the code word field
	localparam int EFF    = (MAX_CODE_LEN < hte_pkg::WORD_W) ? MAX_CODE_LEN : hte_pkg::WORD_W;
	localparam int CLEN_W = $clog2(EFF + 1);
	localparam int AW     = $clog2(SYMBOL_COUNT);
	localparam int ACC_W  = hte_pkg::PEND_W + EFF;

	// captured input beat
	logic [hte_pkg::KIND_W-1:0] kind_q;
	logic [hte_pkg::SYM_W-1:0]  sym_q;
	logic [hte_pkg::WORD_W-1:0] word_q;
	logic [hte_pkg::LEN_W-1:0]  len_q;

	// accumulator and pending state
	logic [ACC_W-1:0]             acc_q;
	logic [hte_pkg::TOTAL_W-1:0]  total_q;
	logic [hte_pkg::PEND_W-1:0]   pend_bits_q;
	logic [hte_pkg::CNT_W-1:0]    pend_cnt_q;

	// output register
	logic                          out_valid_q;
	logic [hte_pkg::BYTE_W-1:0]    out_byte_q;
	logic [hte_pkg::VBITS_W-1:0]   out_vbits_q;
	logic                          out_last_q;

	logic [hte_pkg::LEN_W-1:0]    len_sat;
	logic [hte_pkg::WORD_W:0]     len_mask;
	logic [EFF-1:0]               wr_word;
	logic [EFF-1:0]               rd_word;
	logic [CLEN_W-1:0]            rd_len;
	logic [hte_pkg::TOTAL_W-1:0]  emit_sh;
	logic [hte_pkg::BYTE_W-1:0]   emit_byte;
	logic [hte_pkg::BYTE_W-1:0]   flush_byte;
	logic [hte_pkg::PEND_W-1:0]   pend_mask;
	logic                         out_free;

	// input capture, payload only
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			kind_q <= s_tuser;
			sym_q  <= s_tdata[7:0];
			word_q <= s_tdata[23:8];
			len_q  <= s_tdata[28:24];
		end
	end

	// load: saturate length and drop stray code bits
	always_comb begin
		len_sat  = (len_q > hte_pkg::LEN_W'(EFF)) ? hte_pkg::LEN_W'(EFF) : len_q;
		len_mask = ((hte_pkg::WORD_W+1)'(1) << len_sat) - (hte_pkg::WORD_W+1)'(1);
		wr_word  = word_q[EFF-1:0] & len_mask[EFF-1:0];
	end

	hte_code_store #(
		.SYMBOL_COUNT(SYMBOL_COUNT),
		.CWORD_W     (EFF),
		.CLEN_W      (CLEN_W)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd.wr),
		.rd     (cmd.rd),
		.addr   (sym_q[AW-1:0]),
		.wr_word(wr_word),
		.wr_len (len_sat[CLEN_W-1:0]),
		.rd_word(rd_word),
		.rd_len (rd_len)
	);

	// byte selection and leftover masks
	always_comb begin
		emit_sh    = total_q - hte_pkg::TOTAL_W'(hte_pkg::BYTE_W);
		emit_byte  = hte_pkg::BYTE_W'(acc_q >> emit_sh);
		pend_mask  = (hte_pkg::PEND_W'(1) << total_q[hte_pkg::CNT_W-1:0]) - hte_pkg::PEND_W'(1);
		flush_byte = hte_pkg::BYTE_W'({1'b0, pend_bits_q} <<
			(hte_pkg::VBITS_W'(hte_pkg::BYTE_W) - hte_pkg::VBITS_W'(pend_cnt_q)));
		out_free   = !out_valid_q || m_tready;
	end

	// accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			total_q     <= '0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else begin
			if (cmd.acc_load) begin
				acc_q   <= (ACC_W'(pend_bits_q) << rd_len) | ACC_W'(rd_word);
				total_q <= hte_pkg::TOTAL_W'(pend_cnt_q) + hte_pkg::TOTAL_W'(rd_len);
			end else if (cmd.emit) begin
				total_q <= emit_sh;
			end
			if (cmd.pend_upd) begin
				pend_bits_q <= acc_q[hte_pkg::PEND_W-1:0] & pend_mask;
				pend_cnt_q  <= total_q[hte_pkg::CNT_W-1:0];
			end else if (cmd.flush) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end
		end
	end

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.flush) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q  <= emit_byte;
			out_vbits_q <= hte_pkg::VBITS_W'(hte_pkg::BYTE_W);
			out_last_q  <= 1'b0;
		end else if (cmd.flush) begin
			out_byte_q  <= flush_byte;
			out_vbits_q <= hte_pkg::VBITS_W'(pend_cnt_q);
			out_last_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_vbits_q, out_byte_q};
	assign m_tlast  = out_last_q;

	// status
	always_comb begin
		stat.kind      = hte_pkg::kind_t'(kind_q);
		stat.in_range  = ({1'b0, sym_q} < (hte_pkg::SYM_W+1)'(SYMBOL_COUNT));
		stat.len_zero  = (rd_len == '0);
		stat.total_ge8 = (total_q >= hte_pkg::TOTAL_W'(hte_pkg::BYTE_W));
		stat.out_free  = out_free;
	end

endmodule

`default_nettype wire

// File: sv/hte_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hte_ctrl: sequencing state machine
// Takes one input beat at a time, steers the table access and byte emission,
// and reopens the input once the item is finished.
// ---------------------------------------------------------------------------
module hte_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire hte_pkg::dp_stat_t  stat,
	output hte_pkg::ctrl_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LOOKUP,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   ready_q;

	// commands decoded from state and status
	always_comb begin
		cmd          = '0;
		cmd.cap      = ready_q && s_tvalid;
		case (state_q)
			ST_DISPATCH: begin
				cmd.wr = (stat.kind == hte_pkg::KIND_LOAD) && stat.in_range;
				cmd.rd = (stat.kind == hte_pkg::KIND_ENCODE) && stat.in_range;
			end
			ST_LOOKUP: begin
				cmd.acc_load = !stat.len_zero;
			end
			ST_EMIT: begin
				cmd.emit     = stat.total_ge8 && stat.out_free;
				cmd.pend_upd = !stat.total_ge8;
			end
			ST_FLUSH: begin
				cmd.flush = stat.out_free;
			end
			default: begin
			end
		endcase
	end

	// state and ready register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && ready_q) begin
						state_q <= ST_DISPATCH;
						ready_q <= 1'b0;
					end
				end
				ST_DISPATCH: begin
					case (stat.kind)
						hte_pkg::KIND_ENCODE: begin
							if (stat.in_range) begin
								state_q <= ST_LOOKUP;
							end else begin
								state_q <= ST_IDLE;
								ready_q <= 1'b1;
							end
						end
						hte_pkg::KIND_FLUSH: begin
							state_q <= ST_FLUSH;
						end
						default: begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end
					endcase
				end
				ST_LOOKUP: begin
					if (stat.len_zero) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!stat.total_ge8) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_FLUSH: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign s_tready = ready_q;

endmodule

`default_nettype wire
